### rtl/orc_pkg.sv
// Package for the orientation response confidence block.
// Holds the item structs, reset values, register codes and fixed widths.
// No dependencies; used by the top level.
package orc_pkg;

   // Defaults for the top-level parameters.
   localparam int unsigned NUM_ORIENTATIONS_DEF = 36;
   localparam int unsigned RESPONSE_BITS_DEF    = 16;

   // Fixed widths of the item fields and of the configuration registers.
   localparam int unsigned RESP_FIELD_BITS = 16;
   localparam int unsigned CONF_BITS       = 16;
   localparam int unsigned CFG_BITS        = 6;
   localparam int unsigned CSR_ADDR_BITS   = 3;
   localparam int unsigned CSR_DATA_BITS   = 32;

   // Number of quotient bits produced by the serial divider.
   localparam int unsigned QUOT_BITS = 16;

   // Confidence of 1.0 in Q1.15.
   localparam logic [CONF_BITS-1:0] CONF_ONE = 16'd32768;

   // Reset values of the configuration registers.
   localparam logic [CFG_BITS-1:0] SKIP_TOP_RESET   = 6'd4;
   localparam logic [CFG_BITS-1:0] WINDOW_LEN_RESET = 6'd10;

   // Register index, taken from address bit 2.
   typedef enum logic {
      REG_SKIP_TOP   = 1'b0,
      REG_WINDOW_LEN = 1'b1
   } csr_reg_type;

   // One input item: a filter response and the end-of-pixel flag.
   typedef struct packed {
      logic [RESP_FIELD_BITS-1:0] response;
      logic                       last;
   } req_type;

   // One result item: Q1.15 confidence and the zero-maximum flag.
   typedef struct packed {
      logic [CONF_BITS-1:0] confidence;
      logic                 zero_max;
   } rsp_type;

endpackage

### rtl/orc_ram.sv
// Generic simple dual-port RAM: one write port, one read port.
// Read data is registered. No dependencies.
module orc_ram #(
   parameter int unsigned Width = 16,
   parameter int unsigned Depth = 36,
   localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AddrW-1:0] wr_addr,
   input  logic [Width-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AddrW-1:0] rd_addr,
   output logic [Width-1:0] rd_data
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/orientation_response_confidence_top.sv
// Top level of the orientation response confidence block.
// Depends on orc_pkg (types, constants) and orc_ram (sorted response store).
//
//   channel   ports                      direction   moves
//   req       req_valid/ready, req_data  in          one filter response item
//   rsp       rsp_valid/ready, rsp_data  out         one confidence item per pixel
//   csr       csr_p*                     in/out      skip_top, window_len registers
//
// One sequencer drives a single RAM port pair and a bit-serial divider. A taken
// response item keeps req_ready low while it moves past the stored responses
// smaller than it, one read and one write each, until it reaches its place or
// the top; a full store first checks its smallest entry, and a response not
// larger than that entry is dropped there. An item with last set also runs the
// window sum (over the window length actually used), the multiply, the divide
// unless the maximum is zero or the window empty, and the load of the output
// register, held there while the previous result still waits.
// Reset clears the fill count, so the store needs no clearing pass.
module orientation_response_confidence_top #(
   parameter int unsigned NUM_ORIENTATIONS = orc_pkg::NUM_ORIENTATIONS_DEF,
   parameter int unsigned RESPONSE_BITS    = orc_pkg::RESPONSE_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  orc_pkg::req_type                    req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output orc_pkg::rsp_type                    rsp_data,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [orc_pkg::CSR_ADDR_BITS-1:0]   csr_paddr,
   input  logic [orc_pkg::CSR_DATA_BITS-1:0]   csr_pwdata,
   output logic [orc_pkg::CSR_DATA_BITS-1:0]   csr_prdata,
   output logic                                csr_pready
);

   import orc_pkg::*;

   localparam int unsigned AddrW  = $clog2(NUM_ORIENTATIONS);
   localparam int unsigned FillW  = $clog2(NUM_ORIENTATIONS + 1);
   localparam int unsigned StoreW = (RESPONSE_BITS < RESP_FIELD_BITS) ?
                                    RESPONSE_BITS : RESP_FIELD_BITS;
   localparam int unsigned DenW   = StoreW + FillW;
   localparam int unsigned WinW   = CFG_BITS + 1;
   localparam int unsigned CmpW   = (FillW > WinW) ? FillW : WinW;
   localparam int unsigned QCntW  = $clog2(QUOT_BITS + 1);

   localparam logic [AddrW-1:0] LastIdx   = AddrW'(NUM_ORIENTATIONS - 1);
   localparam logic [FillW-1:0] FullCount = FillW'(NUM_ORIENTATIONS);

   typedef enum logic [9:0] {
      ST_IDLE    = 10'b0000000001,
      ST_INS_RD  = 10'b0000000010,
      ST_INS_CMP = 10'b0000000100,
      ST_MAX_RD  = 10'b0000001000,
      ST_MAX_CAP = 10'b0000010000,
      ST_SUM_RD  = 10'b0000100000,
      ST_SUM_ACC = 10'b0001000000,
      ST_MUL     = 10'b0010000000,
      ST_DIV     = 10'b0100000000,
      ST_OUT     = 10'b1000000000
   } state_type;

   // Control registers.
   state_type             state_ff, state_in;
   logic [FillW-1:0]      fill_ff, fill_in;
   logic [CFG_BITS-1:0]   skip_ff, skip_in;
   logic [CFG_BITS-1:0]   win_ff, win_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   // Working registers.
   logic [StoreW-1:0]     val_ff, val_in;
   logic                  last_ff, last_in;
   logic                  chk_ff, chk_in;
   logic [AddrW-1:0]      idx_ff, idx_in;
   logic [StoreW-1:0]     max_ff, max_in;
   logic [FillW-1:0]      cnt_ff, cnt_in;
   logic [FillW-1:0]      rem_ff, rem_in;
   logic [DenW-1:0]       sum_ff, sum_in;
   logic [DenW-1:0]       denom_ff, denom_in;
   logic [DenW:0]         r_ff, r_in;
   logic [QUOT_BITS-1:0]  q_ff, q_in;
   logic [QCntW-1:0]      qcnt_ff, qcnt_in;
   logic                  zero_ff, zero_in;
   rsp_type               rsp_data_ff, rsp_data_in;

   // Store port signals.
   logic                  ram_wr_en;
   logic [AddrW-1:0]      ram_wr_addr;
   logic [StoreW-1:0]     ram_wr_data;
   logic                  ram_rd_en;
   logic [AddrW-1:0]      ram_rd_addr;
   logic [StoreW-1:0]     ram_rd_data;

   // Helper values.
   logic                  req_fire;
   logic                  csr_write;
   logic [FillW-1:0]      ins_fill;
   logic [CmpW-1:0]       win_end;
   logic [CmpW-1:0]       win_stop;
   logic [FillW-1:0]      win_cnt;
   logic [DenW:0]         div_trial;
   logic [DenW:0]         div_denom;
   csr_reg_type           csr_reg;

   // Sorted response store, largest first.
   orc_ram #(
      .Width (StoreW),
      .Depth (NUM_ORIENTATIONS)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign req_ready  = (state_ff == ST_IDLE);
   assign req_fire   = req_valid && req_ready;
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_reg    = csr_reg_type'(csr_paddr[2]);

   // The fill count saturates at the store depth; a dropped item leaves it full.
   assign ins_fill = (fill_ff == FullCount) ? fill_ff : fill_ff + FillW'(1);

   // Window bounds: cut at the fill count, empty when it starts past the end.
   assign win_end  = CmpW'(skip_ff) + CmpW'(win_ff);
   assign win_stop = (win_end > CmpW'(fill_ff)) ? CmpW'(fill_ff) : win_end;
   assign win_cnt  = (win_stop > CmpW'(skip_ff)) ?
                     FillW'(win_stop - CmpW'(skip_ff)) : '0;

   // Divider step: the first step starts from denom - sum, later ones shift.
   assign div_denom = {1'b0, denom_ff};
   assign div_trial = (qcnt_ff == QCntW'(QUOT_BITS)) ?
                      (DenW + 1)'(denom_ff - sum_ff) : {r_ff[DenW-1:0], 1'b0};

   // Sequencer and datapath next values.
   always_comb begin
      state_in     = state_ff;
      fill_in      = fill_ff;
      skip_in      = skip_ff;
      win_in       = win_ff;
      rsp_valid_in = rsp_valid_ff;
      val_in       = val_ff;
      last_in      = last_ff;
      chk_in       = chk_ff;
      idx_in       = idx_ff;
      max_in       = max_ff;
      cnt_in       = cnt_ff;
      rem_in       = rem_ff;
      sum_in       = sum_ff;
      denom_in     = denom_ff;
      r_in         = r_ff;
      q_in         = q_ff;
      qcnt_in      = qcnt_ff;
      zero_in      = zero_ff;
      rsp_data_in  = rsp_data_ff;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = idx_ff;
      ram_wr_data  = val_ff;
      ram_rd_en    = 1'b0;
      ram_rd_addr  = idx_ff;

      // A delivered result frees the output register.
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            // Take a response; a full store first checks its smallest entry.
            if (req_fire) begin
               val_in   = req_data.response[StoreW-1:0];
               last_in  = req_data.last;
               chk_in   = (fill_ff == FullCount);
               idx_in   = (fill_ff == FullCount) ? LastIdx : AddrW'(fill_ff);
               state_in = ST_INS_RD;
            end
         end
         ST_INS_RD: begin
            // At the top of the store the new response goes in directly.
            if (!chk_ff && (idx_ff == '0)) begin
               ram_wr_en = 1'b1;
               fill_in   = ins_fill;
               state_in  = last_ff ? ST_MAX_RD : ST_IDLE;
            end else begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = chk_ff ? idx_ff : idx_ff - AddrW'(1);
               state_in    = ST_INS_CMP;
            end
         end
         ST_INS_CMP: begin
            // Stop at an entry not smaller than the new one, else move it down.
            if (ram_rd_data >= val_ff) begin
               ram_wr_en = !chk_ff;
               fill_in   = ins_fill;
               state_in  = last_ff ? ST_MAX_RD : ST_IDLE;
            end else if (chk_ff) begin
               chk_in   = 1'b0;
               state_in = ST_INS_RD;
            end else begin
               ram_wr_en   = 1'b1;
               ram_wr_data = ram_rd_data;
               idx_in      = idx_ff - AddrW'(1);
               state_in    = ST_INS_RD;
            end
         end
         ST_MAX_RD: begin
            // Fetch the maximum and set up the window.
            ram_rd_en   = 1'b1;
            ram_rd_addr = '0;
            cnt_in      = win_cnt;
            idx_in      = AddrW'(skip_ff);
            state_in    = ST_MAX_CAP;
         end
         ST_MAX_CAP: begin
            max_in   = ram_rd_data;
            sum_in   = '0;
            rem_in   = cnt_ff;
            state_in = (cnt_ff == '0) ? ST_MUL : ST_SUM_RD;
         end
         ST_SUM_RD: begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = idx_ff;
            idx_in      = idx_ff + AddrW'(1);
            state_in    = ST_SUM_ACC;
         end
         ST_SUM_ACC: begin
            // Accumulate one ranked response of the window.
            sum_in   = sum_ff + DenW'(ram_rd_data);
            rem_in   = rem_ff - FillW'(1);
            state_in = (rem_ff == FillW'(1)) ? ST_MUL : ST_SUM_RD;
         end
         ST_MUL: begin
            // Denominator is count times maximum; special cases skip the divide.
            denom_in = DenW'(cnt_ff) * DenW'(max_ff);
            zero_in  = (max_ff == '0);
            qcnt_in  = QCntW'(QUOT_BITS);
            if (max_ff == '0) begin
               q_in     = '0;
               state_in = ST_OUT;
            end else if (cnt_ff == '0) begin
               q_in     = CONF_ONE;
               state_in = ST_OUT;
            end else begin
               q_in     = '0;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            // Restoring division, one quotient bit per cycle.
            if (div_trial >= div_denom) begin
               r_in = div_trial - div_denom;
               q_in = {q_ff[QUOT_BITS-2:0], 1'b1};
            end else begin
               r_in = div_trial;
               q_in = {q_ff[QUOT_BITS-2:0], 1'b0};
            end
            qcnt_in = qcnt_ff - QCntW'(1);
            if (qcnt_ff == QCntW'(1)) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            // Load the result once the output register is free; empty the store.
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_data_in.confidence = q_ff;
               rsp_data_in.zero_max   = zero_ff;
               rsp_valid_in           = 1'b1;
               fill_in                = '0;
               state_in               = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Configuration writes.
      if (csr_write) begin
         unique case (csr_reg)
            REG_SKIP_TOP:   skip_in = csr_pwdata[CFG_BITS-1:0];
            REG_WINDOW_LEN: win_in  = csr_pwdata[CFG_BITS-1:0];
            default:        skip_in = skip_ff;
         endcase
      end
   end

   // Configuration reads.
   always_comb begin
      unique case (csr_reg)
         REG_SKIP_TOP:   csr_prdata = CSR_DATA_BITS'(skip_ff);
         REG_WINDOW_LEN: csr_prdata = CSR_DATA_BITS'(win_ff);
         default:        csr_prdata = '0;
      endcase
   end

   // Control registers with reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff      <= '0;
         skip_ff      <= SKIP_TOP_RESET;
         win_ff       <= WINDOW_LEN_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         skip_ff      <= skip_in;
         win_ff       <= win_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload and working registers.
   always_ff @(posedge clock) begin
      val_ff      <= val_in;
      last_ff     <= last_in;
      chk_ff      <= chk_in;
      idx_ff      <= idx_in;
      max_ff      <= max_in;
      cnt_ff      <= cnt_in;
      rem_ff      <= rem_in;
      sum_ff      <= sum_in;
      denom_ff    <= denom_in;
      r_ff        <= r_in;
      q_ff        <= q_in;
      qcnt_ff     <= qcnt_in;
      zero_ff     <= zero_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
